>>> rtl/shp_pkg.sv
`timescale 1ns / 1ps

package shp_pkg;

	// Widths fixed by the word fields and the register map.
	localparam int SAMPLE_W  = 8;
	localparam int COLS_W    = 11;
	localparam int ROWS_W    = 12;
	localparam int CHAN_W    = 3;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 4;
	localparam int SUM_W     = 12;

	localparam logic [COLS_W-1:0] COLUMNS_RST  = 11'd640;
	localparam logic [ROWS_W-1:0] ROWS_RST     = 12'd480;
	localparam logic [CHAN_W-1:0] CHANNELS_RST = 3'd1;
	localparam int                MIN_COLUMNS  = 3;
	localparam int                MIN_ROWS     = 3;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

	typedef enum logic [1:0] {
		REG_COLUMNS  = 2'd0,
		REG_ROWS     = 2'd1,
		REG_CHANNELS = 2'd2
	} reg_idx_t;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_FLUSH  = 1'b1
	} req_kind_t;

	// Control from the item stage to the window block.
	typedef struct packed {
		logic update;
		logic interior;
	} win_ctrl_t;

endpackage

>>> rtl/shp_stream_if.sv
`timescale 1ns / 1ps

// Request channel: one image sample or one flush tick per word.
interface shp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [shp_pkg::SAMPLE_W-1:0]  sample;

	modport source(output valid, output req_type, output sample, input ready);
	modport sink(input valid, input req_type, input sample, output ready);
endinterface

// Result channel: one sharpened sample per word.
interface shp_res_if;
	logic                          valid;
	logic                          ready;
	logic [shp_pkg::SAMPLE_W-1:0]  sharpened;
	logic                          frame_end;

	modport source(output valid, output sharpened, output frame_end, input ready);
	modport sink(input valid, input sharpened, input frame_end, output ready);
endinterface

>>> rtl/shp_window.sv
`timescale 1ns / 1ps

module shp_window #(
	parameter int MAX_CHANNELS = 4,
	parameter int PH_W         = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  shp_pkg::win_ctrl_t           ctrl,
	input  logic [PH_W-1:0]              phase,
	input  logic [shp_pkg::SAMPLE_W-1:0] up2,
	input  logic [shp_pkg::SAMPLE_W-1:0] up1,
	input  logic [shp_pkg::SAMPLE_W-1:0] cur,
	output logic [shp_pkg::SAMPLE_W-1:0] value
);
	import shp_pkg::*;

	// Per channel: the three rows of the previous pixel column and the
	// middle row of the column before that.
	logic [SAMPLE_W-1:0] near_top_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] near_mid_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] near_bot_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] far_mid_q  [MAX_CHANNELS];

	logic [SAMPLE_W+2:0]      centre_x5;
	logic [SAMPLE_W+1:0]      neighbours;
	logic signed [SUM_W-1:0]  diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				near_top_q[i] <= '0;
				near_mid_q[i] <= '0;
				near_bot_q[i] <= '0;
				far_mid_q[i]  <= '0;
			end
		end else if (ctrl.update) begin
			far_mid_q[phase]  <= near_mid_q[phase];
			near_top_q[phase] <= up2;
			near_mid_q[phase] <= up1;
			near_bot_q[phase] <= cur;
		end
	end

	always_comb begin
		centre_x5  = {1'b0, near_mid_q[phase], 2'b00} + {3'b000, near_mid_q[phase]};
		neighbours = {2'b00, far_mid_q[phase]} + {2'b00, up1}
			+ {2'b00, near_top_q[phase]} + {2'b00, near_bot_q[phase]};
		diff = $signed({1'b0, centre_x5}) - $signed({2'b00, neighbours});
		priority if (!ctrl.interior || diff < 0) begin
			value = '0;
		end else if (diff > $signed({4'b0000, SAMPLE_MAX})) begin
			value = SAMPLE_MAX;
		end else begin
			value = diff[SAMPLE_W-1:0];
		end
	end

endmodule

>>> rtl/sharpen_3x3_stream_unit.sv
`timescale 1ns / 1ps

// Streaming 3x3 Laplacian sharpen for an 8-bit interleaved image sent in raster
// order, one sample per word. Each interior sample becomes five times itself minus
// its left, right, upper and lower neighbours of the same channel, clamped to
// 0..255; samples on the first and last rows and in the first and last pixel
// columns come out as 0. A result leaves one row plus one pixel after its own
// centre sample, so the first row and the first pixel of the second row give
// no result. After the last sample of a frame, columns*channels plus channels
// results are still owed: send one flush word for each, and the last of them
// carries frame_end. A sample sent while results are owed drops them and starts
// the next frame. The block takes one word every clock cycle unless a result
// waits at a stalled output while the window stage is full. A word passes the
// window stage, fed by the two line memories (each read and written once per
// sample word with a registered read), and then the result register before its
// result shows on the output. The line memories have no clearing pass, so the
// block is ready straight out of reset. Program image_columns (byte address 0),
// image_rows (4) and channel_count (8) over the APB port between frames;
// out-of-range values are clamped to 3..MAX_COLUMNS columns, at least 3 rows
// and 1..MAX_CHANNELS channels.

module sharpen_3x3_stream_unit #(
	parameter int MAX_COLUMNS  = 1024,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	shp_req_if.sink                     items,
	shp_res_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [shp_pkg::APB_AW-1:0]  paddr,
	input  logic [shp_pkg::APB_DW-1:0]  pwdata,
	output logic [shp_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import shp_pkg::*;

	localparam int LINE_DEPTH = MAX_COLUMNS * MAX_CHANNELS;
	localparam int XW         = $clog2(LINE_DEPTH);
	localparam int WW         = $clog2(LINE_DEPTH + MAX_CHANNELS + 1);
	localparam int CLW        = $clog2(MAX_COLUMNS + 1);
	localparam int CW         = $clog2(MAX_CHANNELS + 1);
	localparam int PH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Configuration registers.
	logic [COLS_W-1:0] columns_q;
	logic [ROWS_W-1:0] rows_q;
	logic [CHAN_W-1:0] channels_q;

	// Stream position and the count of results still owed after a frame.
	logic [XW-1:0]     col_q;
	logic [ROWS_W-1:0] row_q;
	logic [PH_W-1:0]   phase_q;
	logic [WW-1:0]     pending_q;

	// Effective frame geometry after clamping.
	logic [CW-1:0]     chan_eff;
	logic [CLW-1:0]    cols_eff;
	logic [ROWS_W-1:0] rows_eff;
	logic [WW-1:0]     row_span;

	// Decode of the word at the input.
	logic in_fire;
	logic is_flush;
	logic past_first_px;
	logic past_second_px;
	logic col_last;
	logic row_last;
	logic row_ge1;
	logic row_ge2;
	logic row_inner;
	logic have_sample;
	logic interior;

	// Line memories: one and two rows above the current position.
	logic [SAMPLE_W-1:0] line_one_mem [LINE_DEPTH];
	logic [SAMPLE_W-1:0] line_two_mem [LINE_DEPTH];

	// Window stage.
	logic                valid_s1;
	logic                sample_item_s1;
	logic                have_s1;
	logic                interior_s1;
	logic                frame_end_s1;
	logic [PH_W-1:0]     phase_s1;
	logic [XW-1:0]       col_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] up1_s1;
	logic [SAMPLE_W-1:0] up2_s1;
	logic                adv_s1;
	win_ctrl_t           win_ctrl;
	logic [SAMPLE_W-1:0] win_value;

	// Result register.
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sharpened_q;
	logic                frame_end_q;

	//--------------------------------------------------------------------------
	// APB register file. Writes take effect at once; the block expects them
	// between frames.
	//--------------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= COLUMNS_RST;
			rows_q     <= ROWS_RST;
			channels_q <= CHANNELS_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_COLUMNS:  columns_q  <= pwdata[COLS_W-1:0];
				REG_ROWS:     rows_q     <= pwdata[ROWS_W-1:0];
				REG_CHANNELS: channels_q <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_COLUMNS:  prdata = APB_DW'(columns_q);
			REG_ROWS:     prdata = APB_DW'(rows_q);
			REG_CHANNELS: prdata = APB_DW'(channels_q);
			default:      prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// Effective geometry. The row span is a narrow multiply by 1..MAX_CHANNELS channels.
	//--------------------------------------------------------------------------
	always_comb begin
		priority if (channels_q == '0) begin
			chan_eff = CW'(1);
		end else if (int'(channels_q) > MAX_CHANNELS) begin
			chan_eff = CW'(MAX_CHANNELS);
		end else begin
			chan_eff = CW'(channels_q);
		end

		priority if (int'(columns_q) < MIN_COLUMNS) begin
			cols_eff = CLW'(MIN_COLUMNS);
		end else if (int'(columns_q) > MAX_COLUMNS) begin
			cols_eff = CLW'(MAX_COLUMNS);
		end else begin
			cols_eff = CLW'(columns_q);
		end

		rows_eff = (int'(rows_q) < MIN_ROWS) ? ROWS_W'(MIN_ROWS) : rows_q;
		row_span = WW'(cols_eff) * WW'(chan_eff);
	end

	//--------------------------------------------------------------------------
	// Input decode. Whether a sample word yields a result, and whether that result is
	// an interior one, depends only on the position, so it is settled here.
	//--------------------------------------------------------------------------
	assign items.ready = !valid_s1 || adv_s1;
	assign in_fire     = items.valid && items.ready;
	assign is_flush    = (req_kind_t'(items.req_type) == REQ_FLUSH);

	always_comb begin
		past_first_px  = WW'(col_q) >= WW'(chan_eff);
		past_second_px = WW'(col_q) >= (WW'(chan_eff) << 1);
		col_last       = (WW'(col_q) + WW'(1)) >= row_span;
		row_last       = ({1'b0, row_q} + 1'b1) >= {1'b0, rows_eff};
		row_ge1        = row_q != '0;
		row_ge2        = row_q >= ROWS_W'(2);
		// The output row is one above the input row; it must not be the last.
		row_inner      = ({1'b0, row_q} + 1'b1) <= {1'b0, rows_eff};
		// In the first pixel column, the result owed is the last pixel column
		// of two rows up, which is border.
		have_sample    = past_first_px ? row_ge1 : row_ge2;
		interior       = past_first_px && past_second_px && row_ge2 && row_inner;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			phase_q   <= '0;
			pending_q <= '0;
		end else if (in_fire) begin
			if (is_flush) begin
				if (pending_q != '0) begin
					pending_q <= pending_q - 1'b1;
				end
			end else begin
				pending_q <= '0;
				if (col_last) begin
					col_q   <= '0;
					phase_q <= '0;
					if (row_last) begin
						row_q     <= '0;
						pending_q <= row_span + WW'(chan_eff);
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q   <= col_q + 1'b1;
					phase_q <= (int'(phase_q) + 1 >= int'(chan_eff)) ? '0 : phase_q + 1'b1;
				end
			end
		end
	end

	//--------------------------------------------------------------------------
	// Line memories. The upper line is written as the word is taken; the line
	// two rows up takes the old upper entry once it has been read, when the
	// word leaves the window stage. The same address comes round again only a
	// full row later, long after that write.
	//--------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire && !is_flush) begin
			line_one_mem[col_q] <= items.sample;
			up1_s1              <= line_one_mem[col_q];
			up2_s1              <= line_two_mem[col_q];
		end
		if (adv_s1 && sample_item_s1) begin
			line_two_mem[col_s1] <= up1_s1;
		end
	end

	//--------------------------------------------------------------------------
	// Window stage.
	//--------------------------------------------------------------------------
	assign adv_s1 = valid_s1 && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_item_s1 <= !is_flush;
			have_s1        <= is_flush ? (pending_q != '0) : have_sample;
			interior_s1    <= !is_flush && interior;
			frame_end_s1   <= is_flush && (pending_q == WW'(1));
			phase_s1       <= phase_q;
			col_s1         <= col_q;
			sample_s1      <= items.sample;
		end
	end

	assign win_ctrl.update   = adv_s1 && sample_item_s1;
	assign win_ctrl.interior = interior_s1;

	shp_window #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.PH_W         (PH_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.phase  (phase_s1),
		.up2    (up2_s1),
		.up1    (up1_s1),
		.cur    (sample_s1),
		.value  (win_value)
	);

	//--------------------------------------------------------------------------
	// Result register. It decouples the output handshake from the window
	// stage, so a word can still enter an empty window stage while a result waits.
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && have_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && have_s1) begin
			sharpened_q <= win_value;
			frame_end_q <= frame_end_s1;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.sharpened = sharpened_q;
	assign results.frame_end = frame_end_q;

endmodule

>>> rtl/shp_checker.sv
`timescale 1ns / 1ps

module shp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [shp_pkg::SAMPLE_W-1:0] sharpened,
	input logic                         frame_end
);

	// A result that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sharpened) && $stable(frame_end))
		else $error("result word changed or dropped while stalled");

	// The end of a frame is always a border result.
	a_frame_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> sharpened == '0)
		else $error("frame_end on a nonzero result");

	// A result rising on an idle output came via the window and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a word taken two cycles before");

	// With the output empty the block always takes a word.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output is empty");

endmodule

bind sharpen_3x3_stream_unit shp_checker u_shp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.sharpened (results.sharpened),
	.frame_end (results.frame_end)
);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import shp_pkg::*;

	// Sizes of the stores the block keeps; they follow its default parameters.
	localparam int LINE_DEPTH   = 4096;
	localparam int MAX_COLS     = 1024;
	localparam int MAX_CHANS    = 4;
	// Cycles to let pass after the last result before touching the registers.
	localparam int PIPE_SETTLE  = 4;
	localparam int TARGET_ITEMS = 700;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		req_kind_t           kind;
		logic [SAMPLE_W-1:0] sample;
	} req_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sharpened;
		logic                frame_end;
	} sharp_res_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Everything driven into the block starts from a known value at time zero.
	logic                tx_valid = 1'b0;
	req_kind_t           tx_kind = REQ_SAMPLE;
	logic [SAMPLE_W-1:0] tx_sample = '0;
	logic                rx_ready = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	shp_req_if req_bus();
	shp_res_if res_bus();

	assign req_bus.valid    = tx_valid;
	assign req_bus.req_type = tx_kind;
	assign req_bus.sample   = tx_sample;
	assign res_bus.ready    = rx_ready;

	sharpen_3x3_stream_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(req_bus),
		.results(res_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Words waiting to be offered, and sharpened samples the block still owes us.
	req_word_t  words_to_send [$];
	sharp_res_t sharpened_due [$];
	req_word_t  tx_word;

	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned results_seen = 0;
	int unsigned items_made = 0;
	int unsigned frames_made = 0;
	int unsigned settings_made = 0;
	int unsigned error_count = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        rx_hold = 1'b0;
	bit          hold_request = 1'b0;

	// Our own copy of the registers as last written, masked to their widths.
	logic [COLS_W-1:0] cfg_columns = COLUMNS_RST;
	logic [ROWS_W-1:0] cfg_rows = ROWS_RST;
	logic [CHAN_W-1:0] cfg_channels = CHANNELS_RST;

	// Shadow of the sharpening pipeline: two previous lines, and for every
	// channel phase the two most recent three-row columns of the window.
	logic [SAMPLE_W-1:0] line_one [LINE_DEPTH];
	logic [SAMPLE_W-1:0] line_two [LINE_DEPTH];
	logic [SAMPLE_W-1:0] win_near [MAX_CHANS][3];
	logic [SAMPLE_W-1:0] win_far [MAX_CHANS][3];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned chan_phase = 0;
	int unsigned owed_outputs = 0;

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// The registers as the block uses them: clamped into their legal ranges.
	function automatic int unsigned chans_in_use();
		if (cfg_channels == 0)
			return 1;
		if (cfg_channels > MAX_CHANS)
			return MAX_CHANS;
		return cfg_channels;
	endfunction

	function automatic int unsigned cols_in_use();
		if (cfg_columns < MIN_COLUMNS)
			return MIN_COLUMNS;
		if (cfg_columns > MAX_COLS)
			return MAX_COLS;
		return cfg_columns;
	endfunction

	function automatic int unsigned rows_in_use();
		return (cfg_rows < MIN_ROWS) ? MIN_ROWS : cfg_rows;
	endfunction

	// Advances the shadow pipeline by one accepted word and queues the sharpened
	// sample it releases, if any. Output lags input by one row plus one pixel,
	// so the sample leaving now is the centre of the window's near column.
	function automatic void predict_sharpened(req_word_t w);
		int unsigned chans, row_len, rows, x, r, ph;
		logic [SAMPLE_W-1:0] up1, up2;
		logic [SAMPLE_W-1:0] near_col [3];
		logic [SAMPLE_W-1:0] far_col [3];
		logic emit;
		int acc;
		sharp_res_t res;

		chans = chans_in_use();
		row_len = cols_in_use() * chans;
		rows = rows_in_use();

		// A flush drains one owed border sample; the last one closes the frame.
		if (w.kind == REQ_FLUSH) begin
			if (owed_outputs != 0) begin
				owed_outputs--;
				res.sharpened = '0;
				res.frame_end = (owed_outputs == 0);
				sharpened_due.push_back(res);
			end
			return;
		end

		// Any sample drops what a previous frame still owed.
		owed_outputs = 0;
		x = col_pos;
		r = row_pos;
		up2 = line_two[x % LINE_DEPTH];
		up1 = line_one[x % LINE_DEPTH];
		line_two[x % LINE_DEPTH] = up1;
		line_one[x % LINE_DEPTH] = w.sample;

		ph = chan_phase % MAX_CHANS;
		near_col = win_near[ph];
		far_col = win_far[ph];

		emit = 1'b0;
		acc = 0;
		if (x >= chans) begin
			if (r >= 1) begin
				emit = 1'b1;
				// Interior only when the output row is neither the first nor the
				// last and the output pixel is not in the first column.
				if (r >= 2 && r + 1 <= rows && x >= 2 * chans) begin
					acc = 5 * int'(near_col[1]) - int'(far_col[1]) - int'(up1)
						- int'(near_col[0]) - int'(near_col[2]);
					if (acc < 0)
						acc = 0;
					if (acc > int'(SAMPLE_MAX))
						acc = int'(SAMPLE_MAX);
				end
			end
		end else if (r >= 2) begin
			// First pixel of a row releases the last pixel two rows up: border.
			emit = 1'b1;
		end

		win_far[ph] = near_col;
		win_near[ph][0] = up2;
		win_near[ph][1] = up1;
		win_near[ph][2] = w.sample;

		if (x + 1 >= row_len) begin
			col_pos = 0;
			chan_phase = 0;
			if (r + 1 >= rows) begin
				row_pos = 0;
				owed_outputs = (row_len + chans) & 'h1FFF;
			end else begin
				row_pos = (r + 1) & 'hFFF;
			end
		end else begin
			col_pos = (x + 1) & 'hFFF;
			chan_phase = (chan_phase + 1 >= chans) ? 0 : chan_phase + 1;
		end

		if (emit) begin
			res.sharpened = acc[SAMPLE_W-1:0];
			res.frame_end = 1'b0;
			sharpened_due.push_back(res);
		end
	endfunction

	function automatic void check_result(logic [SAMPLE_W-1:0] got_value, logic got_end);
		sharp_res_t want;

		results_seen++;
		if (sharpened_due.size() == 0) begin
			flag_error($sformatf("result %0d with nothing owed: sharpened=%0d frame_end=%0b",
				results_seen, got_value, got_end));
			return;
		end
		want = sharpened_due.pop_front();
		if (got_value !== want.sharpened || got_end !== want.frame_end)
			flag_error($sformatf("result %0d: expected sharpened=%0d frame_end=%0b, got %0d %0b",
				results_seen, want.sharpened, want.frame_end, got_value, got_end));
	endfunction

	// Sender: offers the next queued word whenever the bus is free, idling at
	// random. The shadow pipeline is advanced at the edge that takes a word.
	always @(posedge clk) begin
		if (!arst_n) begin
			tx_valid <= 1'b0;
		end else begin
			if (tx_valid && req_bus.ready) begin
				predict_sharpened(tx_word);
				words_taken++;
			end
			if (!tx_valid || req_bus.ready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					tx_word = words_to_send.pop_front();
					tx_valid <= 1'b1;
					tx_kind <= tx_word.kind;
					tx_sample <= tx_word.sample;
				end else begin
					tx_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every word taken off the result bus against the oldest
	// owed sample, then decides whether to stall the next cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (res_bus.valid && rx_ready)
				check_result(res_bus.sharpened, res_bus.frame_end);
			rx_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One long receiver hold-off while the sender keeps pushing, so the block
	// backs up all the way to its input.
	initial begin : backpressure
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return SAMPLE_MAX;
			default: return SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	function automatic void queue_word(req_kind_t kind, logic [SAMPLE_W-1:0] sample);
		req_word_t w;

		w.kind = kind;
		w.sample = sample;
		words_to_send.push_back(w);
		words_queued++;
	endfunction

	function automatic void queue_samples(int unsigned count);
		repeat (count) queue_word(REQ_SAMPLE, rand_sample());
	endfunction

	function automatic void queue_flushes(int unsigned count);
		repeat (count) queue_word(REQ_FLUSH, SAMPLE_W'($urandom_range(255)));
	endfunction

	// One whole frame at the current setting. With noise allowed, stray flush
	// words land mid-frame (nothing is owed there, so they are dropped) and the
	// flush tail is sometimes cut short, letting the next frame's first sample
	// discard what is left, or runs long into flushes with nothing owed.
	function automatic void queue_random_frame(bit allow_noise);
		int unsigned total, owed, n_flush, pick;

		total = cols_in_use() * chans_in_use() * rows_in_use();
		owed = cols_in_use() * chans_in_use() + chans_in_use();
		for (int unsigned i = 0; i < total; i++) begin
			if (allow_noise && $urandom_range(29) == 0)
				queue_flushes(1);
			queue_word(REQ_SAMPLE, rand_sample());
		end
		pick = $urandom_range(9);
		if (!allow_noise || pick >= 2)
			n_flush = owed;
		else if (pick == 0)
			n_flush = $urandom_range(owed - 1);
		else
			n_flush = owed + $urandom_range(1, 3);
		queue_flushes(n_flush);
		items_made += total + ((n_flush < owed) ? n_flush : owed);
		frames_made++;
	endfunction

	// Writes one register over APB and reads it back; the readback must show
	// the field alone, whatever the written value holds above it.
	task automatic program_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] want;

		case (idx)
			REG_COLUMNS: want = APB_DW'(value[COLS_W-1:0]);
			REG_ROWS: want = APB_DW'(value[ROWS_W-1:0]);
			default: want = APB_DW'(value[CHAN_W-1:0]);
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_COLUMNS: cfg_columns = value[COLS_W-1:0];
			REG_ROWS: cfg_rows = value[ROWS_W-1:0];
			default: cfg_channels = value[CHAN_W-1:0];
		endcase
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			flag_error($sformatf("register %s reads %0h, expected %0h", idx.name(), prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_setting(int unsigned cols, int unsigned rows, int unsigned chans);
		logic [APB_DW-1:0] junk;

		junk = $urandom;
		program_reg(REG_COLUMNS, {junk[APB_DW-1:COLS_W], cols[COLS_W-1:0]});
		junk = $urandom;
		program_reg(REG_ROWS, {junk[APB_DW-1:ROWS_W], rows[ROWS_W-1:0]});
		junk = $urandom;
		program_reg(REG_CHANNELS, {junk[APB_DW-1:CHAN_W], chans[CHAN_W-1:0]});
		settings_made++;
	endtask

	// Block is idle once every queued word is taken and every owed sample has
	// come back; a further settling wait covers words still in flight with no result.
	task automatic wait_drained();
		while (words_taken != words_queued || sharpened_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	function automatic void set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 66;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 66;
			end
			default: begin
				send_idle_pct = 9;
				recv_stall_pct = 9;
			end
		endcase
	endfunction

	initial begin : stimulus
		int unsigned seg, n_frames, cols, rows, chans;
		int unsigned spin;

		foreach (line_one[i]) begin
			line_one[i] = '0;
			line_two[i] = '0;
		end
		foreach (win_near[p, k]) begin
			win_near[p][k] = '0;
			win_far[p][k] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the smallest frame, with one interior sample driven to each
		// clamp. A flush before anything is owed is dropped; an extra flush
		// after frame_end is dropped too; the second frame is cut short after
		// two flushes and the next frame's first sample throws the rest away.
		set_idling(IDLE_BOTH);
		apply_setting(3, 3, 1);
		queue_word(REQ_FLUSH, SAMPLE_MAX);
		for (int i = 0; i < 9; i++)
			queue_word(REQ_SAMPLE, (i == 4) ? SAMPLE_MAX : 8'd0);
		queue_flushes(5);
		for (int i = 0; i < 9; i++)
			queue_word(REQ_SAMPLE, (i == 4) ? 8'd0 : SAMPLE_MAX);
		queue_flushes(2);
		frames_made += 2;
		queue_random_frame(1'b0);
		wait_drained();

		// Row count cut down mid-frame, from its largest value: the frame ends
		// at the end of the row in progress, which lies past the new last row.
		set_idling(IDLE_NONE);
		apply_setting(3, 4095, 1);
		queue_samples(12);
		wait_drained();
		program_reg(REG_ROWS, 3);
		queue_samples(3);
		queue_flushes(4);
		frames_made++;
		wait_drained();

		// Row width cut down mid-row: the position already lies past the new
		// width, so the next sample ends the row. Only line entries written in
		// earlier rows are read afterwards.
		apply_setting(8, 4, 1);
		queue_samples(22);
		wait_drained();
		program_reg(REG_COLUMNS, 3);
		queue_samples(4);
		queue_flushes(4);
		frames_made++;
		wait_drained();

		// Register clamping: too few columns with too many channels, then a single
		// column with zero rows and zero channels.
		set_idling(IDLE_RECEIVER);
		apply_setting(0, 5, 7);
		queue_random_frame(1'b1);
		wait_drained();
		set_idling(IDLE_SENDER);
		apply_setting(1, 0, 0);
		queue_random_frame(1'b1);
		wait_drained();

		// Random part: mostly small well-formed frames with random content,
		// rotating through the idling patterns. The first segment runs flat out
		// with the long receiver hold-off on top.
		seg = 0;
		items_made = 0;
		while (items_made < TARGET_ITEMS) begin
			set_idling(idle_mode_t'(seg % 4));
			if (seg == 0) begin
				cols = 10;
				rows = 5;
				chans = 3;
			end else begin
				case ($urandom_range(9))
					0: cols = $urandom_range(2);
					1: cols = $urandom_range(24, 11);
					default: cols = $urandom_range(10, 3);
				endcase
				rows = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
				chans = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
			end
			apply_setting(cols, rows, chans);
			if (seg == 0)
				hold_request = 1'b1;
			n_frames = (seg == 0) ? 2 : $urandom_range(3, 1);
			repeat (n_frames) queue_random_frame(1'b1);
			wait_drained();
			seg++;
		end

		// Drain with a bound, then give the block time to show anything extra.
		set_idling(IDLE_NONE);
		for (spin = 0; spin < 200000; spin++) begin
			if (words_taken == words_queued && sharpened_due.size() == 0)
				break;
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sharpened_due.size() != 0)
			flag_error($sformatf("%0d sharpened samples never arrived", sharpened_due.size()));

		$display("Ran %0d frames over %0d register settings, %0d words sent, %0d results checked.",
			frames_made, settings_made, words_taken, results_seen);
		$display("Mismatches and stray results: %0d.", error_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/shp_pkg.sv
rtl/shp_stream_if.sv
rtl/shp_window.sv
rtl/sharpen_3x3_stream_unit.sv
rtl/shp_checker.sv
dv/tb.sv
